// ----- rtl/crt16_pkg.sv -----
// Package for the 16-bit compare/reset timer: transaction types and codes.
package crt16_pkg;

   localparam int DATA_WIDTH = 16;
   localparam int CTL_WIDTH  = 8;

   // opcodes
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;

   // register indexes
   localparam logic [1:0] REG_CMP_A = 2'd0;
   localparam logic [1:0] REG_CMP_B = 2'd1;
   localparam logic [1:0] REG_COUNT = 2'd2;
   localparam logic [1:0] REG_CTL   = 2'd3;

   // control bit positions
   localparam int CTL_RUN_BIT    = 0;
   localparam int CTL_PRESET_BIT = 1;

   typedef struct packed {
      logic [1:0]            opcode;
      logic [1:0]            reg_index;
      logic [DATA_WIDTH-1:0] write_data;
   } req_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] read_data;
      logic                  match_a_pulse;
      logic                  match_b_pulse;
   } rsp_type;

endpackage

// ----- rtl/compare_reset_timer16_core.sv -----
// Top level of the timer channel with dual compare match and compare-B reset.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------
//   req     | in        | req_valid/req_stall  | opcode, reg_index, write_data
//   rsp     | out       | rsp_valid/rsp_stall  | read_data, match_a_pulse/b_pulse
//
// One transaction per clock while rsp_stall stays low; each one produces exactly one response.
// A request passes the input register, then the state update and result
// register. The counter increment plus two compares set the critical path.
// Reset (synchronous, active high) clears all four timer registers, so the
// timer comes up stopped, and empties both pipeline registers.
// req_stall rises only when the input register is full and the response
// register is held by rsp_stall; a stalled response holds its value.
module compare_reset_timer16_core #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  crt16_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output crt16_pkg::rsp_type  rsp_data
);
   import crt16_pkg::*;

   // input register
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_data_ff;

   // response register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // timer state
   logic [COUNT_WIDTH-1:0] cmp_a_ff, cmp_a_in;
   logic [COUNT_WIDTH-1:0] cmp_b_ff, cmp_b_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [CTL_WIDTH-1:0]   ctl_ff, ctl_in;

   logic                   out_free;
   logic                   advance;
   logic                   accept;
   logic [COUNT_WIDTH-1:0] wr_val;
   logic [COUNT_WIDTH-1:0] next_count;
   logic                   b_hit;
   logic [COUNT_WIDTH-1:0] read_reg;
   logic [DATA_WIDTH-1:0]  read_low;
   logic [CTL_WIDTH-1:0]   ctl_wr;

   // handshake: the response slot is free when empty or being drained
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   assign s1_valid_in  = accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   // bus data fitted to the counter width
   generate
      if (COUNT_WIDTH >= DATA_WIDTH) begin : g_wide
         assign wr_val   = COUNT_WIDTH'(s1_data_ff.write_data);
         assign read_low = read_reg[DATA_WIDTH-1:0];
      end else begin : g_narrow
         assign wr_val   = s1_data_ff.write_data[COUNT_WIDTH-1:0];
         assign read_low = DATA_WIDTH'(read_reg);
      end
   endgenerate

   assign ctl_wr = s1_data_ff.write_data[CTL_WIDTH-1:0];

   // tick step: reset on compare B, else wrap-around increment
   assign b_hit      = (cmp_b_ff != '0) && (count_ff == cmp_b_ff);
   assign next_count = b_hit ? '0 : count_ff + COUNT_WIDTH'(1);

   always_comb begin
      unique case (s1_data_ff.reg_index)
         REG_CMP_A: read_reg = cmp_a_ff;
         REG_CMP_B: read_reg = cmp_b_ff;
         REG_COUNT: read_reg = count_ff;
         default:   read_reg = COUNT_WIDTH'(ctl_ff);
      endcase
   end

   always_comb begin
      cmp_a_in    = cmp_a_ff;
      cmp_b_in    = cmp_b_ff;
      count_in    = count_ff;
      ctl_in      = ctl_ff;
      rsp_data_in = '0;
      unique case (s1_data_ff.opcode)
         OP_TICK: begin
            if (ctl_ff[CTL_RUN_BIT]) begin
               count_in = next_count;
               rsp_data_in.match_a_pulse = (cmp_a_ff != '0) && (next_count == cmp_a_ff);
               rsp_data_in.match_b_pulse = (cmp_b_ff != '0) && (next_count == cmp_b_ff);
            end
         end
         OP_READ: begin
            if (s1_data_ff.reg_index == REG_CTL) begin
               rsp_data_in.read_data = DATA_WIDTH'(ctl_ff);
            end else begin
               rsp_data_in.read_data = read_low;
            end
         end
         OP_WRITE: begin
            unique case (s1_data_ff.reg_index)
               REG_CMP_A: cmp_a_in = wr_val;
               REG_CMP_B: cmp_b_in = wr_val;
               REG_COUNT: count_in = wr_val;
               default: begin
                  // preset clears the counter and is not stored
                  if (ctl_wr[CTL_PRESET_BIT]) begin
                     count_in = '0;
                  end
                  ctl_in = ctl_wr;
                  ctl_in[CTL_PRESET_BIT] = 1'b0;
               end
            endcase
         end
         default: begin
            // unused opcode: no state change, zero result
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cmp_a_ff     <= '0;
         cmp_b_ff     <= '0;
         count_ff     <= '0;
         ctl_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            cmp_a_ff <= cmp_a_in;
            cmp_b_ff <= cmp_b_in;
            count_ff <= count_in;
            ctl_ff   <= ctl_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // preset bit never stays stored
   a_no_preset_stored: assert property (@(posedge clock) disable iff (reset)
      !ctl_ff[CTL_PRESET_BIT])
      else $error("preset bit stored in control register");

   // a control write with preset leaves the counter at zero
   a_preset_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_data_ff.opcode == OP_WRITE && s1_data_ff.reg_index == REG_CTL
       && s1_data_ff.write_data[CTL_PRESET_BIT]) |=> (count_ff == '0))
      else $error("preset write did not clear counter");

   // match pulses come only from ticks, which never carry read data
   a_pulse_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.match_a_pulse || rsp_data_ff.match_b_pulse))
      |-> (rsp_data_ff.read_data == '0))
      else $error("match pulse with nonzero read data");

   // a B match leaves the counter sitting on compare B
   a_b_match_count: assert property (@(posedge clock) disable iff (reset)
      (advance && rsp_data_in.match_b_pulse) |=> (count_ff == cmp_b_ff))
      else $error("compare B match without counter at compare B");

   // input side stalls only while the response slot is held
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid_ff && rsp_stall && s1_valid_ff))
      else $error("request stalled without a held response");

endmodule
